/* rtl/nbrm_pkg.sv */
// Shared types and constants of the byte-range NFA matcher.
package nbrm_pkg;
  typedef enum logic [2:0] {
    OP_RANGE = 3'd0,
    OP_ATTR  = 3'd1,
    OP_NEXT  = 3'd2,
    OP_INIT  = 3'd3,
    OP_START = 3'd4,
    OP_BYTE  = 3'd5
  } op_t;
  localparam int unsigned WORD_W = 64;
  localparam logic CFG_NUM_STATES = 1'b0;
  localparam logic CFG_ACCEPT = 1'b1;

  // Per-state byte test result handed from the range unit to the sequencer.
  typedef struct packed {
    logic done;
    logic fires;
  } test_t;
endpackage

/* rtl/nfa_byte_range_matcher_unit.sv */
// Top level of the byte-range NFA matcher: sequencer, tables and flags.
// Table writes, unused opcodes, start and bytes while dead: the result is valid
// the cycle after the transfer; the next is taken once the result is accepted.
// A byte walks states 0..num_states-1; a skipped state has only its attrs step,
// a visited one also its range compares, then its next-mask reads if it fires.
// Synchronous active-low reset resets the flags, the init and active sets, the
// sequencer state and the configuration registers; tables are not cleared.
module nfa_byte_range_matcher_unit #(
  parameter int unsigned STATES = 256,
  parameter int unsigned MAX_RANGES = 8,
  parameter int unsigned MASK_WORDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_state_index,
  input  logic [2:0]  in_range_slot,
  input  logic [1:0]  in_word_index,
  input  logic [7:0]  in_range_low,
  input  logic [7:0]  in_range_high,
  input  logic        in_inverted,
  input  logic [3:0]  in_range_count,
  input  logic [63:0] in_mask_word,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_alive,
  output logic        out_accepting,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import nbrm_pkg::*;
  localparam int unsigned SW = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int unsigned RSW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned WW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
  localparam int unsigned RD = STATES * MAX_RANGES;
  localparam int unsigned ND = STATES * MASK_WORDS;
  localparam int unsigned RAW = $clog2(RD > 1 ? RD : 2);
  localparam int unsigned NAW = $clog2(ND > 1 ? ND : 2);
  localparam int unsigned SAW = $clog2(STATES > 1 ? STATES : 2);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1) + 1;
  localparam int unsigned BITS = MASK_WORDS * WORD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ATTR, S_RANGE, S_NEXT, S_NEXTW, S_FINISH, S_OUT
  } state_t;

  state_t state_r;
  logic [8:0] num_states_r;
  logic [7:0] accept_r;
  logic [BITS-1:0] init_r, active_r, fresh_r;
  logic alive_r, acc_r, any_r;
  logic [8:0] st_r;          // state being visited, may reach STATES
  logic [WW:0] word_r;
  logic [CW-1:0] ridx_r;
  logic [7:0] byte_r;

  // Used-state count and in-use mask.
  logic [8:0] nused;
  logic [BITS-1:0] use_mask;
  always_comb begin
    nused = (32'(num_states_r) > STATES) ? 9'(STATES) : num_states_r;
    for (int b = 0; b < BITS; b++) use_mask[b] = (b < 32'(nused));
  end

  // Table memories.
  logic rng_we, att_we, nxt_we;
  logic [RAW-1:0] rng_wa, rng_ra;
  logic [NAW-1:0] nxt_wa, nxt_ra;
  logic [SAW-1:0] att_wa, att_ra;
  logic [15:0] rng_rd;
  logic [4:0] att_rd;
  logic [63:0] nxt_rd;
  logic idx_ok;
  logic [RSW-1:0] ridx_rd;

  // Range reads run one entry ahead so each entry lands with its compare.
  assign ridx_rd = (state_r == S_RANGE) ? RSW'(ridx_r + 1'b1) : '0;

  assign idx_ok = 32'(in_state_index) < STATES;
  assign rng_we = (state_r == S_IDLE) && in_valid && in_opcode == OP_RANGE && idx_ok &&
                  32'(in_range_slot) < MAX_RANGES;
  assign att_we = (state_r == S_IDLE) && in_valid && in_opcode == OP_ATTR && idx_ok;
  assign nxt_we = (state_r == S_IDLE) && in_valid && in_opcode == OP_NEXT && idx_ok &&
                  32'(in_word_index) < MASK_WORDS;
  assign rng_wa = RAW'(32'(in_state_index) * MAX_RANGES + 32'(in_range_slot));
  assign att_wa = SAW'(in_state_index);
  assign nxt_wa = NAW'(32'(in_state_index) * MASK_WORDS + 32'(in_word_index));
  assign att_ra = SAW'(st_r);
  assign rng_ra = RAW'(32'(st_r[SW-1:0]) * MAX_RANGES + 32'(ridx_rd));
  assign nxt_ra = NAW'(32'(st_r[SW-1:0]) * MASK_WORDS + 32'(word_r[WW-1:0]));

  nbrm_ram #(.WIDTH(16), .DEPTH(RD)) u_rng (
    .clk, .we(rng_we), .waddr(rng_wa), .wdata({in_range_low, in_range_high}),
    .raddr(rng_ra), .rdata(rng_rd));
  nbrm_ram #(.WIDTH(5), .DEPTH(STATES)) u_att (
    .clk, .we(att_we), .waddr(att_wa), .wdata({in_inverted, in_range_count}),
    .raddr(att_ra), .rdata(att_rd));
  nbrm_ram #(.WIDTH(64), .DEPTH(ND)) u_nxt (
    .clk, .we(nxt_we), .waddr(nxt_wa), .wdata(in_mask_word),
    .raddr(nxt_ra), .rdata(nxt_rd));

  // Range compare unit: the attrs read of st_r drives the limit while st_r
  // holds, range RAM feeds entries.
  logic ru_start, ru_run, ru_active;
  test_t ru_test;
  nbrm_range_unit #(.MAX_RANGES(MAX_RANGES)) u_ru (
    .clk, .start(ru_start), .run(ru_run), .data_byte(byte_r),
    .range_entry(rng_rd), .attrs(att_rd), .active(ru_active), .test(ru_test));

  // Range index mirrors the unit's compare index.
  logic st_active, st_skip;
  assign st_active = active_r[st_r[SW-1:0]];
  assign st_skip = !st_active || (st_r[7:0] == accept_r);
  assign ru_start = (state_r == S_ATTR);
  assign ru_run = (state_r == S_RANGE);
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_alive = alive_r;
  assign out_accepting = acc_r;

  logic [WW-1:0] wsel;
  logic [BITS-1:0] word_sh;
  assign wsel = WW'(word_r - 1'b1);
  assign word_sh = BITS'(nxt_rd) << (32'(wsel) * WORD_W);

  logic [BITS-1:0] start_set;
  logic [BITS-1:0] acc_bit;
  logic acc_ok;
  assign acc_ok = 32'(accept_r) < 32'(nused);
  assign acc_bit = acc_ok ? (BITS'(1) << accept_r) : '0;
  assign start_set = init_r & use_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      num_states_r <= 9'd256;
      accept_r <= '0;
      init_r <= '0;
      active_r <= '0;
      alive_r <= 1'b0;
      acc_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_STATES) num_states_r <= cfg_data;
        else accept_r <= cfg_data[7:0];
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_OUT;
            case (in_opcode)
              OP_INIT: if (32'(in_word_index) < MASK_WORDS)
                init_r[32'(in_word_index[WW-1:0]) * WORD_W +: WORD_W] <= in_mask_word;
              OP_START: begin
                active_r <= start_set & ~acc_bit;
                acc_r <= |(start_set & acc_bit);
                alive_r <= 1'b1;
              end
              OP_BYTE: if (alive_r) begin
                byte_r <= in_data_byte;
                st_r <= '0;
                fresh_r <= '0;
                any_r <= 1'b0;
                state_r <= (nused == 0) ? S_FINISH : S_ATTR;
              end
              default: ;
            endcase
          end
        end
        S_ATTR: begin
          // Attrs read for st_r is issued now; skip states that cannot fire.
          ridx_r <= '0;
          if (st_skip) begin
            if (st_r + 1'b1 >= nused) state_r <= S_FINISH;
            st_r <= st_r + 1'b1;
          end else state_r <= S_RANGE;
        end
        S_RANGE: begin
          if (ru_active) ridx_r <= ridx_r + 1'b1;
          if (ru_test.done) begin
            word_r <= '0;
            if (ru_test.fires) state_r <= S_NEXT;
            else begin
              if (st_r + 1'b1 >= nused) state_r <= S_FINISH;
              else state_r <= S_ATTR;
              st_r <= st_r + 1'b1;
            end
          end
        end
        S_NEXT: begin
          // Issue read of word 0; words land in S_NEXTW from the registered RAM read.
          word_r <= word_r + 1'b1;
          state_r <= S_NEXTW;
        end
        S_NEXTW: begin
          fresh_r <= fresh_r | (word_sh & use_mask);
          if (|(word_sh & use_mask)) any_r <= 1'b1;
          if (32'(word_r) >= MASK_WORDS) begin
            if (st_r + 1'b1 >= nused) state_r <= S_FINISH;
            else state_r <= S_ATTR;
            st_r <= st_r + 1'b1;
          end else word_r <= word_r + 1'b1;
        end
        S_FINISH: begin
          active_r <= fresh_r & ~acc_bit;
          acc_r <= |(fresh_r & acc_bit);
          alive_r <= any_r;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/nbrm_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module nbrm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/nbrm_range_unit.sv */
// Shared byte-against-range compare unit, one range per cycle while run is high.
module nbrm_range_unit #(
  parameter int unsigned MAX_RANGES = 8
) (
  input  logic                  clk,
  input  logic                  start,
  input  logic                  run,
  input  logic [7:0]            data_byte,
  input  logic [15:0]           range_entry,
  input  logic [4:0]            attrs,
  output logic                  active,
  output nbrm_pkg::test_t       test
);
  import nbrm_pkg::*;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1) + 1;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] lim;
  logic matched_r, matched_nxt;
  logic [4:0] cnt5;
  logic hit;

  always_comb begin
    cnt5 = {1'b0, attrs[3:0]};
    if (32'(cnt5) > MAX_RANGES) lim = CW'(MAX_RANGES);
    else lim = CW'(cnt5);
    hit = (data_byte >= range_entry[15:8]) && (data_byte <= range_entry[7:0]);
    idx_nxt = idx_r;
    matched_nxt = matched_r;
    if (start) begin
      idx_nxt = '0;
      matched_nxt = 1'b0;
    end else if (run && idx_r < lim) begin
      idx_nxt = idx_r + 1'b1;
      matched_nxt = matched_r | hit;
    end
    active = run && !start && (idx_r < lim);
    test.done = run && !start && (idx_r >= lim);
    test.fires = attrs[4] ? !matched_r : matched_r;
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    matched_r <= matched_nxt;
  end
endmodule

/* rtl/nbrm_checker.sv */
// Port-level checker for the matcher, bound to the top level.
module nbrm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_alive,
  input logic out_accepting
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("no busy after transfer");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_alive)) else
    $error("result dropped");
  a_dead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_alive) |-> !$isunknown(out_accepting)) else $error("x flag");
endmodule

bind nfa_byte_range_matcher_unit nbrm_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_alive, .out_accepting);

/* bench/tb.sv */
// Testbench for nfa_byte_range_matcher_unit: scoreboard with an NFA predictor and random traffic.
`timescale 1ns / 1ps

module tb;
  import nbrm_pkg::*;

  // Opcodes that the package leaves unnamed; the block must ignore them.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int IDLE_LIMIT = 20000;
  // States with every table entry written; higher states never fire.
  localparam int FULL_STATES = 32;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  sidx;
    logic [2:0]  slot;
    logic [1:0]  widx;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        inv;
    logic [3:0]  cnt;
    logic [63:0] mw;
    logic [7:0]  db;
  } item_t;

  // Bit-parallel NFA predictor plus the queue of flags it has worked out.
  class nfa_scoreboard;
    logic [7:0]   rng_lo[256][8];
    logic [7:0]   rng_hi[256][8];
    logic         st_inv[256];
    logic [3:0]   st_cnt[256];
    logic [255:0] next_set[256];
    logic [255:0] init_set;
    logic [255:0] active;
    logic         alive;
    logic         acc;
    logic [8:0]   num_states;
    logic [7:0]   accept_idx;
    logic [1:0]   flags_due[$];
    int           errors;
    int           shown;

    function new();
      init_set = '0;
      active = '0;
      alive = 0;
      acc = 0;
      num_states = 9'd256;
      accept_idx = 8'd0;
      errors = 0;
      shown = 0;
    endfunction

    function void set_cfg(logic idx, logic [8:0] v);
      if (idx == CFG_NUM_STATES) num_states = v;
      else accept_idx = v[7:0];
    endfunction

    function int used();
      return (num_states > 256) ? 256 : int'(num_states);
    endfunction

    function logic [255:0] in_use();
      logic [255:0] m;
      m = '0;
      for (int i = 0; i < used(); i++) m[i] = 1'b1;
      return m;
    endfunction

    // Move the accept bit out of the set; it is unreachable past num_states.
    function logic take_accept(ref logic [255:0] set);
      logic was;
      if (int'(accept_idx) >= used()) return 1'b0;
      was = set[accept_idx];
      set[accept_idx] = 1'b0;
      return was;
    endfunction

    function logic fires(int s, logic [7:0] b);
      int n;
      logic hit;
      n = (st_cnt[s] > 8) ? 8 : int'(st_cnt[s]);
      hit = 0;
      for (int r = 0; r < n; r++)
        if (b >= rng_lo[s][r] && b <= rng_hi[s][r]) hit = 1;
      return st_inv[s] ? !hit : hit;
    endfunction

    function void note_input(item_t it);
      logic [255:0] fresh;
      logic [255:0] m;
      logic         any;
      case (it.op)
        OP_RANGE: begin
          rng_lo[it.sidx][it.slot] = it.lo;
          rng_hi[it.sidx][it.slot] = it.hi;
        end
        OP_ATTR: begin
          st_inv[it.sidx] = it.inv;
          st_cnt[it.sidx] = it.cnt;
        end
        OP_NEXT: next_set[it.sidx][it.widx*64 +: 64] = it.mw;
        OP_INIT: init_set[it.widx*64 +: 64] = it.mw;
        OP_START: begin
          active = init_set & in_use();
          acc = take_accept(active);
          alive = 1;
        end
        OP_BYTE: begin
          if (alive) begin
            fresh = '0;
            any = 0;
            for (int i = 0; i < used(); i++) begin
              if (active[i] && i != int'(accept_idx) && fires(i, it.db)) begin
                m = next_set[i] & in_use();
                if (m != '0) any = 1;
                fresh |= m;
              end
            end
            acc = take_accept(fresh);
            active = fresh;
            alive = any;
          end
        end
        default: ;
      endcase
      flags_due.push_back({alive, acc});
    endfunction

    function void check(logic a, logic c);
      logic [1:0] exp_flags;
      if (flags_due.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: alive=%0b accepting=%0b", a, c);
        end
        return;
      end
      exp_flags = flags_due.pop_front();
      if (exp_flags[1] !== a || exp_flags[0] !== c) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: alive exp %0b got %0b, accepting exp %0b got %0b",
                   exp_flags[1], a, exp_flags[0], c);
        end
      end
    endfunction

    function int pending();
      return flags_due.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_opcode = '0;
  logic [7:0]  in_state_index = '0;
  logic [2:0]  in_range_slot = '0;
  logic [1:0]  in_word_index = '0;
  logic [7:0]  in_range_low = '0;
  logic [7:0]  in_range_high = '0;
  logic        in_inverted = 0;
  logic [3:0]  in_range_count = '0;
  logic [63:0] in_mask_word = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_alive;
  logic        out_accepting;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [8:0]  cfg_data = '0;

  nfa_scoreboard sb = new();
  int n_results = 0;
  int burst_left = 0;
  bit gaps_on = 1;

  nfa_byte_range_matcher_unit i_dut (.*);

  always #4 clk = ~clk;

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check(out_alive, out_accepting);
      n_results++;
    end
  end

  // Receiver stall pattern: modes are picked at random over the run; one long hold
  // early on, while the sender keeps offering, so the block backs up.
  int rx_cyc = 0;
  int rx_mode = 0;
  int hold_left = 0;
  bit held_once = 0;
  always @(posedge clk) begin
    rx_cyc++;
    if (!held_once && n_results >= 200) begin
      held_once = 1;
      hold_left = 500;
    end
    if (rx_cyc % 256 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= rx_cyc[3];
      endcase
    end
  end

  // Watchdog: end the run if nothing transfers on either side for too long.
  int idle_cyc = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc > IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic item_t rand_item(logic [2:0] op);
    item_t it;
    it.op = op;
    it.sidx = 8'($urandom_range(0, 255));
    it.slot = 3'($urandom_range(0, 7));
    it.widx = 2'($urandom_range(0, 3));
    it.lo = 8'($urandom_range(0, 255));
    it.hi = 8'($urandom_range(0, 255));
    it.inv = 1'($urandom_range(0, 1));
    it.cnt = 4'($urandom_range(0, 15));
    it.mw = {$urandom(), $urandom()};
    it.db = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Offer one item, holding it until the transfer; valid stays high afterwards.
  task automatic send(item_t it);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_opcode <= it.op;
    in_state_index <= it.sidx;
    in_range_slot <= it.slot;
    in_word_index <= it.widx;
    in_range_low <= it.lo;
    in_range_high <= it.hi;
    in_inverted <= it.inv;
    in_range_count <= it.cnt;
    in_mask_word <= it.mw;
    in_data_byte <= it.db;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  // Drain all results, then write both registers while the block is idle.
  task automatic configure(logic [8:0] ns, logic [7:0] acc_state);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NUM_STATES;
    cfg_data <= ns;
    @(posedge clk);
    sb.set_cfg(CFG_NUM_STATES, ns);
    cfg_index <= CFG_ACCEPT;
    cfg_data <= {1'b0, acc_state};
    @(posedge clk);
    sb.set_cfg(CFG_ACCEPT, {1'b0, acc_state});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_range(int s, int slot, int lo, int hi);
    item_t it;
    it = rand_item(OP_RANGE);
    it.sidx = 8'(s);
    it.slot = 3'(slot);
    it.lo = 8'(lo);
    it.hi = 8'(hi);
    send(it);
  endtask

  task automatic send_attr(int s, logic inv, int cnt);
    item_t it;
    it = rand_item(OP_ATTR);
    it.sidx = 8'(s);
    it.inv = inv;
    it.cnt = 4'(cnt);
    send(it);
  endtask

  task automatic send_mask(logic [2:0] op, int s, int w, logic [63:0] mw);
    item_t it;
    it = rand_item(op);
    it.sidx = 8'(s);
    it.widx = 2'(w);
    it.mw = mw;
    send(it);
  endtask

  task automatic send_byte(int b);
    item_t it;
    it = rand_item(OP_BYTE);
    it.db = 8'(b);
    send(it);
  endtask

  // One random phase: mostly byte streams after a start, with table rewrites.
  task automatic run_phase(int n_items);
    int pick;
    int lim;
    item_t it;
    lim = (sb.used() > FULL_STATES) ? FULL_STATES : sb.used();
    for (int w = 0; w < 4; w++) send_mask(OP_INIT, 0, w, {$urandom(), $urandom()});
    send(rand_item(OP_START));
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send(rand_item(OP_BYTE));
      end else if (pick < 63) begin
        send(rand_item(OP_START));
      end else if (pick < 75) begin
        it = rand_item(OP_RANGE);
        // Lean toward wide ranges so states actually fire.
        if ($urandom_range(0, 1)) begin
          it.lo = 8'($urandom_range(0, 60));
          it.hi = 8'($urandom_range(150, 255));
        end
        it.sidx = 8'($urandom_range(0, lim - 1));
        send(it);
      end else if (pick < 83) begin
        it = rand_item(OP_ATTR);
        it.sidx = 8'($urandom_range(0, lim - 1));
        send(it);
      end else if (pick < 92) begin
        it = rand_item(OP_NEXT);
        it.sidx = 8'($urandom_range(0, lim - 1));
        send(it);
      end else if (pick < 97) begin
        send(rand_item(OP_INIT));
      end else begin
        send(rand_item($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7));
      end
    end
  endtask

  int n_rand;
  int ns;

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the low states fully; higher states get attrs that never fire,
    // so no byte ever uses an unwritten entry.
    for (int s = 0; s < 256; s++) begin
      if (s < FULL_STATES) begin
        for (int r = 0; r < 8; r++)
          send_range(s, r, $urandom_range(0, 127), $urandom_range(64, 255));
        send_attr(s, 1'($urandom_range(0, 1)), $urandom_range(0, 15));
        for (int w = 0; w < 4; w++) send_mask(OP_NEXT, s, w, {$urandom(), $urandom()});
      end else begin
        send_attr(s, 1'b0, 0);
      end
    end

    // Directed: four states, accept is state 3.
    configure(9'd4, 8'd3);
    send_byte(8'h41);                       // dead before any start: ignored
    send_range(0, 0, 8'h00, 8'h00);         // lowest byte only
    send_range(0, 1, 8'h80, 8'h10);         // reversed range matches nothing
    send_attr(0, 1'b0, 2);
    send_mask(OP_NEXT, 0, 0, 64'h2);
    send_range(1, 0, 8'hff, 8'hff);
    send_attr(1, 1'b1, 15);                 // count above the limit, inverted
    send_mask(OP_NEXT, 1, 0, 64'h8);
    send_mask(OP_NEXT, 2, 0, '1);
    send_mask(OP_NEXT, 2, 3, '1);
    send_mask(OP_INIT, 0, 0, 64'h9);        // accept present at start
    send_mask(OP_INIT, 0, 3, '1);
    send(rand_item(OP_START));
    send_byte(8'h00);
    send_byte(8'h90);
    send_byte(8'hff);
    send_byte(8'h7f);
    send(rand_item(OP_SPARE6));
    send(rand_item(OP_SPARE7));
    send_mask(OP_INIT, 0, 0, 64'h4);
    send(rand_item(OP_START));
    send_byte(8'h00);
    send_byte(8'hff);

    // Extreme settings first, then random ones; small sizes keep bytes cheap.
    configure(9'd1, 8'd0);   run_phase(40);
    configure(9'd256, 8'd255); run_phase(12);
    configure(9'd8, 8'd200); run_phase(60); // accept beyond the states in use
    gaps_on = 0;
    configure(9'd256, 8'd0); run_phase(12);
    gaps_on = 1;
    n_rand = 806;
    while (n_rand < 1350) begin
      ns = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 256) : $urandom_range(1, 16);
      configure(9'(ns), ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, ns - 1)));
      gaps_on = ($urandom_range(0, 3) != 0);
      run_phase(ns > 16 ? 10 : 80);
      n_rand += (ns > 16) ? 15 : 85;
    end

    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
